[design/wkvt_pkg.sv]
// Package for the worst-K violation tracker: field widths, slot layout and
// default table depth. No dependencies.
package wkvt_pkg;

  localparam int unsigned KeepCountDef = 10;
  localparam int unsigned ValW         = 32;
  localparam int unsigned CntW         = 32;

  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // One table slot: three coordinates and the audited value
  typedef struct packed {
    logic [ValW-1:0] x;
    logic [ValW-1:0] u;
    logic [ValW-1:0] y;
    logic [ValW-1:0] val;
  } slot_t;

endpackage

[design/wkvt_cmp.sv]
// Shared ordering comparator of the tracker: signed value first, slot index
// second. Depends on wkvt_pkg.
module wkvt_cmp import wkvt_pkg::*; #(
  parameter int unsigned IdxW = 4
) (
  input  logic [ValW-1:0] a_val_i,
  input  logic [IdxW-1:0] a_idx_i,
  input  logic [ValW-1:0] b_val_i,
  input  logic [IdxW-1:0] b_idx_i,
  output logic            lt_o
);

  logic [ValW+IdxW-1:0] key_a;
  logic [ValW+IdxW-1:0] key_b;

  // Flip the sign bit so that an unsigned compare orders signed values
  assign key_a = {~a_val_i[ValW-1], a_val_i[ValW-2:0], a_idx_i};
  assign key_b = {~b_val_i[ValW-1], b_val_i[ValW-2:0], b_idx_i};
  assign lt_o  = key_a < key_b;

endmodule

[design/wkvt_stats.sv]
// Running statistics of the tracker: least value seen and saturating count
// of violations. Depends on wkvt_pkg.
module wkvt_stats import wkvt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  logic [ValW-1:0] val_i,
  output logic            viol_o,
  output logic [ValW-1:0] least_o,
  output logic [CntW-1:0] count_o
);

  logic [ValW-1:0] least_q, least_d;
  logic [CntW-1:0] count_q, count_d;

  // A violation is a value at or below zero
  assign viol_o = val_i[ValW-1] || (val_i == '0);

  // Track minimum and saturate the count
  always_comb begin
    least_d = least_q;
    count_d = count_q;
    if (upd_i) begin
      if ($signed(val_i) < $signed(least_q)) begin
        least_d = val_i;
      end
      if (viol_o && (count_q != CntMax)) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q <= ValMax;
      count_q <= '0;
    end else begin
      least_q <= least_d;
      count_q <= count_d;
    end
  end

  assign least_o = least_q;
  assign count_o = count_q;

endmodule

[design/worst_k_violation_tracker.sv]
// Top level of the worst-K violation tracker: sequencer, slot memory and
// result registers. Depends on wkvt_pkg, wkvt_cmp and wkvt_stats.
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------
//  request   start_i && !busy_o        req_type_i, coord_x/u/y_i, sample_value_i
//  result    res_valid_o (one cycle)   running_min_o, bad_count_o, entry_*_o,
//                                      last_o
//
//  Offer, non-violating or table not full: taken in the accept cycle, busy
//  stays low. Offer into a full table: busy for one memory read per slot
//  through the shared comparator, then a compare and write-back.
//  Report of n entries: n selection passes (read, eligibility and best steps
//  per slot), each then a fetch and emit; each result appears in the cycle
//  after its emit. Empty report: one result the cycle after accept.
//  Reset is asynchronous and clears control and statistics only; slot memory
//  is not cleared. The receiver cannot stall results.
module worst_k_violation_tracker import wkvt_pkg::*; #(
  parameter int unsigned KEEP_COUNT = KeepCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            req_type_i,
  input  logic [ValW-1:0] coord_x_i,
  input  logic [ValW-1:0] coord_u_i,
  input  logic [ValW-1:0] coord_y_i,
  input  logic [ValW-1:0] sample_value_i,
  output logic            res_valid_o,
  output logic [ValW-1:0] running_min_o,
  output logic [CntW-1:0] bad_count_o,
  output logic            entry_valid_o,
  output logic [ValW-1:0] entry_x_o,
  output logic [ValW-1:0] entry_u_o,
  output logic [ValW-1:0] entry_y_o,
  output logic [ValW-1:0] entry_val_o,
  output logic            last_o
);

  localparam int unsigned IdxW  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int unsigned FillW = $clog2(KEEP_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MAXCMP,
    S_REPL,
    S_ELIG,
    S_BEST,
    S_FETCH,
    S_EMIT
  } state_e;

  state_e          state_q;
  logic [FillW-1:0] filled_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] pass_q;
  logic [IdxW-1:0] best_idx_q;
  logic [ValW-1:0] best_val_q;
  logic            have_q;
  logic [ValW-1:0] prev_val_q;
  logic [IdxW-1:0] prev_idx_q;
  logic            have_prev_q;
  logic            elig_q;
  slot_t           sample_q;
  logic            req_report_q;

  logic            res_valid_q;
  logic [ValW-1:0] running_min_q;
  logic [CntW-1:0] bad_count_q;
  logic            entry_valid_q;
  slot_t           entry_q;
  logic            last_q;

  slot_t           mem_q [KEEP_COUNT];
  slot_t           rdata_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_t           wr_data;

  logic            accept;
  logic            offer;
  logic            viol;
  logic            not_full;
  logic [IdxW-1:0] last_idx;
  logic [ValW-1:0] least_seen;
  logic [CntW-1:0] violations;

  logic [ValW-1:0] cmp_a_val;
  logic [IdxW-1:0] cmp_a_idx;
  logic [ValW-1:0] cmp_b_val;
  logic [IdxW-1:0] cmp_b_idx;
  logic            cmp_lt;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign offer    = accept && !req_type_i;
  assign not_full = filled_q < FillW'(KEEP_COUNT);
  assign last_idx = IdxW'(filled_q - FillW'(1));

  wkvt_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (offer),
    .val_i   (sample_value_i),
    .viol_o  (viol),
    .least_o (least_seen),
    .count_o (violations)
  );

  // Route operands to the shared comparator by sequencer step
  always_comb begin
    cmp_a_val = rdata_q.val;
    cmp_a_idx = idx_q;
    cmp_b_val = best_val_q;
    cmp_b_idx = best_idx_q;
    case (state_q)
      S_MAXCMP: begin
        cmp_a_val = best_val_q;
        cmp_a_idx = '0;
        cmp_b_val = rdata_q.val;
        cmp_b_idx = '0;
      end
      S_REPL: begin
        cmp_a_val = sample_q.val;
        cmp_a_idx = '0;
        cmp_b_val = best_val_q;
        cmp_b_idx = '0;
      end
      S_ELIG: begin
        cmp_a_val = prev_val_q;
        cmp_a_idx = prev_idx_q;
        cmp_b_val = rdata_q.val;
        cmp_b_idx = idx_q;
      end
      default: begin
        cmp_a_val = rdata_q.val;
        cmp_a_idx = idx_q;
        cmp_b_val = best_val_q;
        cmp_b_idx = best_idx_q;
      end
    endcase
  end

  wkvt_cmp #(
    .IdxW (IdxW)
  ) u_cmp (
    .a_val_i (cmp_a_val),
    .a_idx_i (cmp_a_idx),
    .b_val_i (cmp_b_val),
    .b_idx_i (cmp_b_idx),
    .lt_o    (cmp_lt)
  );

  // Memory port control: append at accept, replace after a full scan
  always_comb begin
    rd_en   = (state_q == S_RD) || (state_q == S_FETCH);
    rd_addr = (state_q == S_FETCH) ? best_idx_q : idx_q;
    wr_en   = 1'b0;
    wr_addr = filled_q[IdxW-1:0];
    wr_data = '{x: coord_x_i, u: coord_u_i, y: coord_y_i, val: sample_value_i};
    if (offer && viol && not_full) begin
      wr_en = 1'b1;
    end else if ((state_q == S_REPL) && cmp_lt) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_q;
      wr_data = sample_q;
    end
  end

  // Slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filled_q    <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      have_q      <= 1'b0;
      have_prev_q <= 1'b0;
      elig_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sample_q <= '{x: coord_x_i, u: coord_u_i, y: coord_y_i,
                          val: sample_value_i};
            idx_q    <= '0;
            have_q   <= 1'b0;
            if (!req_type_i) begin
              if (viol) begin
                if (not_full) begin
                  filled_q <= filled_q + FillW'(1);
                end else begin
                  state_q <= S_RD;
                end
              end
            end else if (filled_q == '0) begin
              // Empty table: one invalid result straight away
              res_valid_q   <= 1'b1;
              running_min_q <= least_seen;
              bad_count_q   <= violations;
              entry_valid_q <= 1'b0;
              entry_q       <= '0;
              last_q        <= 1'b1;
            end else begin
              pass_q      <= '0;
              have_prev_q <= 1'b0;
              state_q     <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= req_report_q ? S_ELIG : S_MAXCMP;
        end
        S_MAXCMP: begin
          // Keep the first slot holding the largest value
          if (!have_q || cmp_lt) begin
            best_val_q <= rdata_q.val;
            best_idx_q <= idx_q;
            have_q     <= 1'b1;
          end
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == IdxW'(KEEP_COUNT - 1)) begin
            state_q <= S_REPL;
          end else begin
            state_q <= S_RD;
          end
        end
        S_REPL: begin
          state_q <= S_IDLE;
        end
        S_ELIG: begin
          elig_q  <= !have_prev_q || cmp_lt;
          state_q <= S_BEST;
        end
        S_BEST: begin
          // Smallest key above the one emitted last
          if (elig_q && (!have_q || cmp_lt)) begin
            best_val_q <= rdata_q.val;
            best_idx_q <= idx_q;
            have_q     <= 1'b1;
          end
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == last_idx) begin
            state_q <= S_FETCH;
          end else begin
            state_q <= S_RD;
          end
        end
        S_FETCH: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          res_valid_q   <= 1'b1;
          running_min_q <= least_seen;
          bad_count_q   <= violations;
          entry_valid_q <= 1'b1;
          entry_q       <= rdata_q;
          last_q        <= (pass_q == last_idx);
          prev_val_q    <= best_val_q;
          prev_idx_q    <= best_idx_q;
          have_prev_q   <= 1'b1;
          have_q        <= 1'b0;
          idx_q         <= '0;
          pass_q        <= pass_q + IdxW'(1);
          if (pass_q == last_idx) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Report runs are told apart from full-table offers by the held request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_report_q <= 1'b0;
    end else if (accept) begin
      req_report_q <= req_type_i;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign running_min_o = running_min_q;
  assign bad_count_o   = bad_count_q;
  assign entry_valid_o = entry_valid_q;
  assign entry_x_o     = entry_q.x;
  assign entry_u_o     = entry_q.u;
  assign entry_y_o     = entry_q.y;
  assign entry_val_o   = entry_q.val;
  assign last_o        = last_q;

endmodule
